// ===== hdl/urltok_pkg.sv =====
// urltok_pkg: shared types and constants of the url stream tokenizer
// parse modes, result kinds, character codes and the job word that
// travels from the front part through the queue to the back part
`default_nettype none

package urltok_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_SCHEME = 3'd1,
    MODE_HOST   = 3'd2,
    MODE_PORT   = 3'd3,
    MODE_PATH   = 3'd4,
    MODE_QUERY  = 3'd5,
    MODE_FRAG   = 3'd6,
    MODE_FAILED = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_HOST   = 3'd0,
    KIND_PATH   = 3'd1,
    KIND_QNAME  = 3'd2,
    KIND_QVALUE = 3'd3,
    KIND_PEND   = 3'd4,
    KIND_FRAG   = 3'd5,
    KIND_DONE   = 3'd6
  } kind_t;

  // configuration register indexes
  localparam logic REG_PLAIN_PORT  = 1'b0;
  localparam logic REG_SECURE_PORT = 1'b1;

  localparam logic [15:0] PLAIN_PORT_RESET  = 16'd80;
  localparam logic [15:0] SECURE_PORT_RESET = 16'd443;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;

  // result slots of one job, emitted from bit 0 upward
  localparam int SLOT_BYTE = 0;
  localparam int SLOT_PEND = 1;
  localparam int SLOT_PATH = 2;
  localparam int SLOT_DONE = 3;
  localparam int NSLOTS    = 4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    kind_t             b_kind;
    logic [7:0]        b_char;
    logic [15:0]       port;
    logic              secure;
    logic              error;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/urltok_front.sv =====
// urltok_front: takes url bytes, runs the parse state machine and builds
// one job word per byte that causes results; holds the default port registers
// depends on urltok_pkg
`default_nettype none

module urltok_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  input  wire logic [7:0]           char_in,
  input  wire logic                 final_byte,
  input  wire logic                 q_ready,
  output logic                      push_valid,
  output urltok_pkg::job_t          push_data
);

  logic [15:0] plain_port;
  logic [15:0] secure_port;

  urltok_pkg::mode_t mode, mode_next;
  logic [2:0]  spos, spos_next;
  logic        sec, sec_next;
  logic [15:0] accum, accum_next;
  logic        path_seen, path_seen_next;
  logic        query_seen, query_seen_next;
  logic        in_value, in_value_next;
  logic        err, err_next;

  logic        accept;
  logic [7:0]  lc;
  logic        is_digit;
  logic        run_scheme;
  logic        sfail;
  logic        err_done;
  logic        b_valid;
  urltok_pkg::kind_t b_kind;
  logic [7:0]  b_char;
  logic [15:0] port_sel;

  assign accept = in_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plain_port  <= urltok_pkg::PLAIN_PORT_RESET;
      secure_port <= urltok_pkg::SECURE_PORT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == urltok_pkg::REG_PLAIN_PORT) begin
        plain_port <= cfg_data;
      end
      if (cfg_index == urltok_pkg::REG_SECURE_PORT) begin
        secure_port <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      mode       <= urltok_pkg::MODE_START;
      spos       <= 3'd0;
      sec        <= 1'b0;
      accum      <= 16'd0;
      path_seen  <= 1'b0;
      query_seen <= 1'b0;
      in_value   <= 1'b0;
      err        <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      spos       <= spos_next;
      sec        <= sec_next;
      accum      <= accum_next;
      path_seen  <= path_seen_next;
      query_seen <= query_seen_next;
      in_value   <= in_value_next;
      err        <= err_next;
    end
  end

  always_comb begin
    lc       = (char_in >= urltok_pkg::CH_UA && char_in <= urltok_pkg::CH_UZ) ?
               (char_in | 8'h20) : char_in;
    is_digit = (char_in >= urltok_pkg::CH_ZERO) && (char_in <= urltok_pkg::CH_NINE);

    mode_next       = mode;
    spos_next       = spos;
    sec_next        = sec;
    accum_next      = accum;
    path_seen_next  = path_seen;
    query_seen_next = query_seen;
    in_value_next   = in_value;
    err_next        = err;
    run_scheme      = 1'b0;
    sfail           = 1'b0;
    b_valid         = 1'b0;
    b_kind          = urltok_pkg::KIND_HOST;
    b_char          = char_in;

    case (mode)
      urltok_pkg::MODE_START: begin
        if (char_in == urltok_pkg::CH_SLASH) begin
          mode_next      = urltok_pkg::MODE_PATH;
          path_seen_next = 1'b1;
          b_valid        = 1'b1;
          b_kind         = urltok_pkg::KIND_PATH;
        end else begin
          mode_next  = urltok_pkg::MODE_SCHEME;
          run_scheme = 1'b1;
        end
      end
      urltok_pkg::MODE_SCHEME: begin
        run_scheme = 1'b1;
      end
      urltok_pkg::MODE_HOST: begin
        if (char_in == urltok_pkg::CH_COLON) begin
          mode_next = urltok_pkg::MODE_PORT;
        end else if (char_in == urltok_pkg::CH_QMARK) begin
          mode_next = urltok_pkg::MODE_QUERY;
        end else if (char_in == urltok_pkg::CH_HASH) begin
          mode_next = urltok_pkg::MODE_FRAG;
        end else if (char_in == urltok_pkg::CH_SLASH) begin
          mode_next      = urltok_pkg::MODE_PATH;
          path_seen_next = 1'b1;
          b_valid        = 1'b1;
          b_kind         = urltok_pkg::KIND_PATH;
        end else begin
          b_valid = 1'b1;
        end
      end
      urltok_pkg::MODE_PORT: begin
        if (char_in == urltok_pkg::CH_QMARK) begin
          mode_next = urltok_pkg::MODE_QUERY;
        end else if (char_in == urltok_pkg::CH_HASH) begin
          mode_next = urltok_pkg::MODE_FRAG;
        end else if (char_in == urltok_pkg::CH_SLASH) begin
          mode_next      = urltok_pkg::MODE_PATH;
          path_seen_next = 1'b1;
          b_valid        = 1'b1;
          b_kind         = urltok_pkg::KIND_PATH;
        end else if (is_digit) begin
          // times ten as two shifts, wraps at 16 bits
          accum_next = {accum[12:0], 3'b000} + {accum[14:0], 1'b0}
                       + {12'd0, char_in[3:0]};
        end
      end
      urltok_pkg::MODE_PATH: begin
        if (char_in == urltok_pkg::CH_QMARK) begin
          mode_next = urltok_pkg::MODE_QUERY;
        end else if (char_in == urltok_pkg::CH_HASH) begin
          mode_next = urltok_pkg::MODE_FRAG;
        end else begin
          path_seen_next = 1'b1;
          b_valid        = 1'b1;
          b_kind         = urltok_pkg::KIND_PATH;
        end
      end
      urltok_pkg::MODE_QUERY: begin
        if (char_in == urltok_pkg::CH_HASH) begin
          mode_next = urltok_pkg::MODE_FRAG;
        end else begin
          query_seen_next = 1'b1;
          if (char_in == urltok_pkg::CH_AMP) begin
            in_value_next = 1'b0;
            b_valid       = 1'b1;
            b_kind        = urltok_pkg::KIND_PEND;
            b_char        = 8'd0;
          end else if (in_value) begin
            b_valid = 1'b1;
            b_kind  = urltok_pkg::KIND_QVALUE;
          end else if (char_in == urltok_pkg::CH_EQ) begin
            in_value_next = 1'b1;
          end else begin
            b_valid = 1'b1;
            b_kind  = urltok_pkg::KIND_QNAME;
          end
        end
      end
      urltok_pkg::MODE_FRAG: begin
        b_valid = 1'b1;
        b_kind  = urltok_pkg::KIND_FRAG;
      end
      default: begin
      end
    endcase

    // "http" [s] "://" with leading spaces skipped
    if (run_scheme) begin
      case (spos)
        3'd0: begin
          if (char_in != urltok_pkg::CH_SPACE) begin
            if (lc == urltok_pkg::CH_H) spos_next = 3'd1;
            else sfail = 1'b1;
          end
        end
        3'd1: if (lc == urltok_pkg::CH_T) spos_next = 3'd2; else sfail = 1'b1;
        3'd2: if (lc == urltok_pkg::CH_T) spos_next = 3'd3; else sfail = 1'b1;
        3'd3: if (lc == urltok_pkg::CH_P) spos_next = 3'd4; else sfail = 1'b1;
        3'd4: begin
          if (lc == urltok_pkg::CH_S) begin
            sec_next  = 1'b1;
            spos_next = 3'd5;
          end else if (char_in == urltok_pkg::CH_COLON) begin
            spos_next = 3'd6;
          end else begin
            sfail = 1'b1;
          end
        end
        3'd5: if (char_in == urltok_pkg::CH_COLON) spos_next = 3'd6; else sfail = 1'b1;
        3'd6: if (char_in == urltok_pkg::CH_SLASH) spos_next = 3'd7; else sfail = 1'b1;
        default: begin
          if (char_in == urltok_pkg::CH_SLASH) begin
            spos_next = 3'd0;
            mode_next = urltok_pkg::MODE_HOST;
          end else begin
            sfail = 1'b1;
          end
        end
      endcase
      if (sfail) begin
        mode_next = urltok_pkg::MODE_FAILED;
        err_next  = 1'b1;
      end
    end

    // ending partway through the scheme text counts as a mismatch
    err_done = err_next || (mode_next == urltok_pkg::MODE_SCHEME && spos_next != 3'd0);

    if (accum_next == 16'd0) port_sel = sec_next ? secure_port : plain_port;
    else port_sel = accum_next;

    push_data.mask[urltok_pkg::SLOT_BYTE] = b_valid;
    push_data.mask[urltok_pkg::SLOT_PEND] = final_byte && !err_done && query_seen_next;
    push_data.mask[urltok_pkg::SLOT_PATH] = final_byte && !err_done && !path_seen_next;
    push_data.mask[urltok_pkg::SLOT_DONE] = final_byte;
    push_data.b_kind = b_kind;
    push_data.b_char = b_char;
    push_data.port   = port_sel;
    push_data.secure = sec_next;
    push_data.error  = err_done;

    push_valid = accept && (push_data.mask != '0);
  end

endmodule

`default_nettype wire

// ===== hdl/urltok_queue.sv =====
// urltok_queue: short first-in first-out queue of job words between the
// front and back parts of the tokenizer
// depends on urltok_pkg
`default_nettype none

module urltok_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire urltok_pkg::job_t push_data,
  output logic                  ready,
  output logic                  head_valid,
  output urltok_pkg::job_t      head_data,
  input  wire logic             pop
);

  urltok_pkg::job_t entries [urltok_pkg::QDEPTH];
  logic [urltok_pkg::QAW-1:0] wr_ptr;
  logic [urltok_pkg::QAW-1:0] rd_ptr;
  logic [urltok_pkg::QCW-1:0] count;

  assign ready      = (count != urltok_pkg::QCW'(urltok_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/urltok_back.sv =====
// urltok_back: expands each queued job into its result words, one per
// cycle unless out_ready stalls, through a registered output stage
// depends on urltok_pkg
`default_nettype none

module urltok_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire urltok_pkg::job_t head_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output urltok_pkg::kind_t     kind,
  output logic [7:0]            char_out,
  output logic [15:0]           port,
  output logic                  secure,
  output logic                  error,
  output logic                  run_end
);

  logic [urltok_pkg::NSLOTS-1:0] sent;
  logic [urltok_pkg::NSLOTS-1:0] pending;
  logic [urltok_pkg::NSLOTS-1:0] pick;
  logic                          last;
  logic                          load;

  urltok_pkg::kind_t kind_sel;
  logic [7:0]        char_sel;
  logic [15:0]       port_sel;
  logic              sec_sel;
  logic              err_sel;

  always_comb begin
    pending = head_data.mask & ~sent;
    pick    = pending & (~pending + 1'b1);
    last    = ((pending & ~pick) == '0);
    load    = head_valid && (!out_valid || out_ready);
    pop     = load && last;

    kind_sel = urltok_pkg::KIND_DONE;
    char_sel = 8'd0;
    port_sel = 16'd0;
    sec_sel  = 1'b0;
    err_sel  = 1'b0;
    if (pick[urltok_pkg::SLOT_BYTE]) begin
      kind_sel = head_data.b_kind;
      char_sel = head_data.b_char;
    end else if (pick[urltok_pkg::SLOT_PEND]) begin
      kind_sel = urltok_pkg::KIND_PEND;
    end else if (pick[urltok_pkg::SLOT_PATH]) begin
      kind_sel = urltok_pkg::KIND_PATH;
      char_sel = urltok_pkg::CH_SLASH;
    end else begin
      port_sel = head_data.port;
      sec_sel  = head_data.secure;
      err_sel  = head_data.error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      sent      <= last ? '0 : (sent | pick);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind     <= kind_sel;
      char_out <= char_sel;
      port     <= port_sel;
      secure   <= sec_sel;
      error    <= err_sel;
      run_end  <= last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/url_stream_tokenizer.sv =====
// url stream tokenizer: takes one url byte per word on the slave side and
// sends each byte on tagged as host, path, query name, query value or fragment,
// and a done word on the last byte. A byte is taken in every cycle while the
// four-entry job queue has room; each byte gives as many result words as it
// causes (none for delimiters and skipped bytes, up to four on the last byte),
// so the sustained rate is one result word per cycle while m_tready is high,
// set by the single output register. A result passes through a job queue entry
// and the output register. Default ports are to be written through the cfg
// port only while idle; the block itself does not enforce this.
// depends on urltok_pkg, urltok_front, urltok_queue, urltok_back
`default_nettype none

module url_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  input  wire logic        s_tlast,   // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] char_out, [23:8] port, [24] secure, [25] error
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast    // run_end
);

  logic              push_valid;
  urltok_pkg::job_t  push_data;
  logic              q_ready;
  logic              head_valid;
  urltok_pkg::job_t  head_data;
  logic              pop;
  urltok_pkg::kind_t kind;
  logic [7:0]        char_out;
  logic [15:0]       port;
  logic              secure;
  logic              error;

  assign s_tready = q_ready;

  urltok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .char_in    (s_tdata),
    .final_byte (s_tlast),
    .q_ready    (q_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  urltok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_data  (push_data),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  urltok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .kind       (kind),
    .char_out   (char_out),
    .port       (port),
    .secure     (secure),
    .error      (error),
    .run_end    (m_tlast)
  );

  assign m_tuser = kind;
  assign m_tdata = {6'd0, error, secure, port, char_out};

  // a done word always closes the run of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == urltok_pkg::KIND_DONE |-> m_tlast)
    else $error("done word without run end");

  // only done words carry port, secure and error
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind != urltok_pkg::KIND_DONE |-> port == 16'd0 && !secure && !error)
    else $error("status fields set on a character word");

  // the queue is never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> q_ready)
    else $error("job queue overflow");

  // a popped job leaves through the output register at that edge
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid && m_tlast)
    else $error("popped job did not end its run");

endmodule

`default_nettype wire
